// ===== rtl/hqd_pkg.sv =====
package hqd_pkg;

  localparam int SAMPLE_WIDTH  = 16;
  localparam int FRACTION_BITS = 13;

  // packer: up to 7 bits held between samples, up to 15 right after a symbol
  localparam int HOLD_WIDTH = 7;
  localparam int ACC_WIDTH  = 15;

  // output queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic signed [SAMPLE_WIDTH-1:0] ONE_POS = SAMPLE_WIDTH'(1 << FRACTION_BITS);
  localparam logic signed [SAMPLE_WIDTH-1:0] ONE_NEG = -ONE_POS;

  typedef enum logic [2:0] {
    MODE_BPSK   = 3'd0,
    MODE_QPSK   = 3'd1,
    MODE_QAM16  = 3'd2,
    MODE_QAM64  = 3'd3,
    MODE_QAM256 = 3'd4
  } mode_t;

  // one decided symbol, handed from the decision stage to the packer
  typedef struct packed {
    logic       valid;
    logic [7:0] sym;
    logic [3:0] nbits;
    logic       last;
  } hqd_sym_t;

  // up to two packed bytes produced by one symbol
  typedef struct packed {
    logic [1:0] count;
    logic [7:0] byte0;
    logic       last0;
    logic [7:0] byte1;
    logic       last1;
  } hqd_push_t;

  // clamp to [-1, 1] and round to one of 2^bits levels
  function automatic logic [3:0] level_index(input logic signed [SAMPLE_WIDTH-1:0] x,
                                             input logic [2:0] bits);
    logic signed [SAMPLE_WIDTH-1:0] xc;
    logic [FRACTION_BITS+1:0]       u;
    logic [FRACTION_BITS+5:0]       t;
    xc = x;
    if (x < ONE_NEG) xc = ONE_NEG;
    if (x > ONE_POS) xc = ONE_POS;
    u = (FRACTION_BITS+2)'(xc + ONE_POS);
    // u * (levels - 1) + one, levels - 1 = 2^bits - 1
    t = ((FRACTION_BITS+6)'(u) << bits) - (FRACTION_BITS+6)'(u)
        + (FRACTION_BITS+6)'(1 << FRACTION_BITS);
    return 4'(t >> (FRACTION_BITS + 1));
  endfunction

endpackage

// ===== rtl/hqd_decision.sv =====
module hqd_decision import hqd_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  logic                           advance,
  input  logic signed [SAMPLE_WIDTH-1:0] in_phase,
  input  logic signed [SAMPLE_WIDTH-1:0] quadrature,
  input  logic                           frame_end,
  input  logic [2:0]                     mode,
  output hqd_sym_t                       dec
);

  logic                           valid;
  logic signed [SAMPLE_WIDTH-1:0] i_reg;
  logic signed [SAMPLE_WIDTH-1:0] q_reg;
  logic                           last_reg;

  logic signed [SAMPLE_WIDTH:0] iq_sum;
  logic [2:0]                   half;
  logic [3:0]                   i_idx;
  logic [3:0]                   q_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      i_reg    <= in_phase;
      q_reg    <= quadrature;
      last_reg <= frame_end;
    end
  end

  always_comb begin
    unique case (mode_t'(mode))
      MODE_BPSK:   half = 3'd0;
      MODE_QPSK:   half = 3'd1;
      MODE_QAM16:  half = 3'd2;
      MODE_QAM64:  half = 3'd3;
      MODE_QAM256: half = 3'd4;
      default:     half = 3'd4;  // unused codes act as 256-qam
    endcase
  end

  always_comb begin
    iq_sum = (SAMPLE_WIDTH+1)'(i_reg) + (SAMPLE_WIDTH+1)'(q_reg);
    i_idx  = level_index(i_reg, half);
    q_idx  = level_index(q_reg, half);
    dec.valid = valid;
    dec.last  = last_reg;
    if (half == 3'd0) begin
      dec.nbits = 4'd1;
      dec.sym   = {7'd0, (iq_sum > 0)};
    end else begin
      dec.nbits = {half, 1'b0};
      dec.sym   = 8'(i_idx) | (8'(q_idx) << half);
    end
  end

endmodule

// ===== rtl/hqd_packer.sv =====
module hqd_packer import hqd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  hqd_sym_t  dec,
  output hqd_push_t push
);

  logic [HOLD_WIDTH-1:0] acc;
  logic [2:0]            cnt;
  logic [HOLD_WIDTH-1:0] acc_next;
  logic [2:0]            cnt_next;

  logic [ACC_WIDTH-1:0]  comb;
  logic [3:0]            sum;
  logic [2:0]            rest;
  logic                  full;
  logic [7:0]            full_byte;
  logic [HOLD_WIDTH-1:0] rem;
  logic [2:0]            rem_cnt;
  logic                  flush;
  logic [7:0]            flush_byte;

  always_comb begin
    comb = (ACC_WIDTH'(acc) << dec.nbits) | ACC_WIDTH'(dec.sym);
    sum  = {1'b0, cnt} + dec.nbits;
    full = sum[3];
    rest = sum[2:0];
    full_byte = 8'(comb >> rest);
    if (full) begin
      rem     = HOLD_WIDTH'(comb) & ((HOLD_WIDTH'(1) << rest) - HOLD_WIDTH'(1));
      rem_cnt = rest;
    end else begin
      rem     = HOLD_WIDTH'(comb);
      rem_cnt = sum[2:0];
    end
    flush      = dec.last && (rem_cnt != 3'd0);
    flush_byte = {1'b0, rem} << (4'd8 - {1'b0, rem_cnt});

    push.count = {1'b0, full} + {1'b0, flush};
    push.byte1 = flush_byte;
    push.last1 = 1'b1;
    if (full) begin
      push.byte0 = full_byte;
      push.last0 = dec.last && (rest == 3'd0);
    end else begin
      push.byte0 = flush_byte;
      push.last0 = 1'b1;
    end

    if (flush) begin
      acc_next = '0;
      cnt_next = '0;
    end else begin
      acc_next = rem;
      cnt_next = rem_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      cnt <= '0;
    end else if (advance) begin
      acc <= acc_next;
      cnt <= cnt_next;
    end
  end

endmodule

// ===== rtl/hqd_out_fifo.sv =====
module hqd_out_fifo import hqd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  hqd_push_t  push,
  output logic       room,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_byte,
  output logic       byte_last
);

  logic [8:0]         mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;
  logic [FIFO_AW-1:0] wr_ptr_next;
  logic [FIFO_CW-1:0] count_next;
  logic [1:0]         n_push;
  logic               pop;

  assign room      = count <= FIFO_CW'(FIFO_DEPTH - 2);
  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;
  assign n_push    = wr_en ? push.count : 2'd0;
  assign data_byte = mem[rd_ptr][8:1];
  assign byte_last = mem[rd_ptr][0];

  always_comb begin
    wr_ptr_next = wr_ptr + FIFO_AW'(n_push);
    count_next  = count + FIFO_CW'(n_push) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_ptr] <= {push.byte0, push.last0};
    end
    if (n_push == 2'd2) begin
      mem[wr_ptr + FIFO_AW'(1)] <= {push.byte1, push.last1};
    end
  end

endmodule

// ===== rtl/hard_decision_qam_demapper_core.sv =====
// sample path: a sample accepted into the sample register has its bytes written to the output queue
//   when that register advances, which waits until the queue has room for two bytes; out_valid
//   rises once the queue holds a byte. throughput: one sample per cycle while the queue has room;
//   one byte per output transaction, so a frame end that yields two bytes needs two output transactions;
//   the output queue has 4 entries. reset (rst, synchronous): clears the packer, the queue and the mode register (bpsk)
module hard_decision_qam_demapper_core import hqd_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic [2:0]                     cfg_wr_data,
  // sample input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0] in_phase,
  input  logic signed [SAMPLE_WIDTH-1:0] quadrature,
  input  logic                           frame_end,
  // byte output
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     data_byte,
  output logic                           byte_last
);

  logic [2:0] modulation_mode;
  hqd_sym_t   dec;
  hqd_push_t  push;
  logic       room;
  logic       advance;
  logic       load;

  // mode register; the user must write it only while the block is idle, the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      modulation_mode <= 3'(MODE_BPSK);
    end else if (cfg_wr_en) begin
      modulation_mode <= cfg_wr_data;
    end
  end

  // the sample register moves on whenever the queue can take two more bytes,
  // which is the worst case for one symbol
  assign advance  = dec.valid && room;
  assign in_ready = !dec.valid || advance;
  assign load     = in_valid && in_ready;

  // input register plus slicer: bpsk sign test or per-axis clamp and round
  hqd_decision u_decision (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .advance    (advance),
    .in_phase   (in_phase),
    .quadrature (quadrature),
    .frame_end  (frame_end),
    .mode       (modulation_mode),
    .dec        (dec)
  );

  // shifts symbol bits in msb first, emits full bytes and the flushed tail
  hqd_packer u_packer (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .dec     (dec),
    .push    (push)
  );

  // result register: small queue that takes up to two bytes per cycle
  hqd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (advance),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data_byte (data_byte),
    .byte_last (byte_last)
  );

endmodule
